// ===== design/tctt_pkg.sv =====
// Shared constants and types for the transfer completion tracking table.
package tctt_pkg;
  localparam int TableDepthDef = 32;
  localparam int GroupCountDef = 16;
  localparam int TagBitsDef = 16;
  localparam int IdW = 64;
  localparam int TagW = 16;
  localparam int GrpW = 4;
  localparam int CntW = 6;
  localparam logic [CntW-1:0] CntMax = 6'd63;

  localparam logic [1:0] ModeCommit = 2'd0;
  localparam logic [1:0] ModeBind = 2'd1;
  localparam logic [1:0] ModeFinish = 2'd2;
  localparam logic [1:0] ModeCheck = 2'd3;

  localparam logic [1:0] StNotFound = 2'd0;
  localparam logic [1:0] StPending = 2'd1;
  localparam logic [1:0] StComplete = 2'd2;
  localparam logic [1:0] StFull = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture request
    logic execute;  // apply operation to table
  } tctt_cmd_t;
endpackage

// ===== design/tctt_ctrl.sv =====
// Controller: sequences load, execute and result hand-off.
module tctt_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output tctt_pkg::tctt_cmd_t cmd
);
  import tctt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;
  state_t state_r;

  // Accept only when idle; the result waits in the output register
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign cmd.load = (state_r == S_IDLE) && in_valid;
  assign cmd.execute = (state_r == S_EXEC);

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) state_r <= S_EXEC;
        S_EXEC: state_r <= S_OUT;
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/tctt_dp.sv =====
// Datapath: entry table, group counters, matching and compaction.
module tctt_dp #(
  parameter int TABLE_DEPTH = tctt_pkg::TableDepthDef,
  parameter int GROUP_COUNT = tctt_pkg::GroupCountDef,
  parameter int TAG_BITS = tctt_pkg::TagBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  tctt_pkg::tctt_cmd_t cmd,
  input  logic [1:0] in_mode,
  input  logic [tctt_pkg::IdW-1:0] in_request_id,
  input  logic [tctt_pkg::TagW-1:0] in_waiter_tag,
  input  logic in_wait_kind,
  input  logic [tctt_pkg::GrpW-1:0] in_waiter_group,
  output logic [1:0] out_status,
  output logic out_respond,
  output logic [tctt_pkg::TagW-1:0] out_respond_tag,
  output logic out_respond_kind
);
  import tctt_pkg::*;

  localparam int TW = (TAG_BITS < TagW) ? TAG_BITS : TagW;
  localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
  localparam int PW = $clog2(TABLE_DEPTH);

  logic [1:0] mode_r;
  logic [IdW-1:0] id_r;
  logic [TW-1:0] tag_r;
  logic kind_r;
  logic [GW-1:0] grp_r;

  logic [TABLE_DEPTH-1:0] vld_r, cmp_r, bnd_r, knd_r;
  logic [IdW-1:0] eid_r [TABLE_DEPTH];
  logic [TW-1:0] etag_r [TABLE_DEPTH];
  logic [GW-1:0] egrp_r [TABLE_DEPTH];
  logic [CntW-1:0] cnt_r [GROUP_COUNT];

  logic [1:0] st_r;
  logic rsp_r, rkind_r;
  logic [TagW-1:0] rtag_r;

  // Reduce group modulo the counter count through a small constant table
  logic [GW-1:0] grp_mod;
  always_comb begin
    grp_mod = '0;
    for (int v = 0; v < (1 << GrpW); v++)
      if (in_waiter_group == GrpW'(v)) grp_mod = GW'(v % GROUP_COUNT);
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      id_r <= in_request_id;
      tag_r <= in_waiter_tag[TW-1:0];
      kind_r <= in_wait_kind;
      grp_r <= grp_mod;
    end
  end

  // Parallel compare and priority selects
  logic [TABLE_DEPTH-1:0] hit, bhit;
  logic any_hit, any_b, full;
  logic [PW-1:0] first_pos, bpos, free_pos;
  always_comb begin
    any_hit = 1'b0; any_b = 1'b0; full = 1'b1;
    first_pos = '0; bpos = '0; free_pos = '0;
    for (int i = TABLE_DEPTH-1; i >= 0; i--) begin
      hit[i] = vld_r[i] && (eid_r[i] == id_r);
      bhit[i] = hit[i] && bnd_r[i];
      if (hit[i]) begin any_hit = 1'b1; first_pos = PW'(i); end
      if (bhit[i]) begin any_b = 1'b1; bpos = PW'(i); end
      if (!vld_r[i]) begin full = 1'b0; free_pos = PW'(i); end
    end
  end

  // Choose removal position for finish and check
  logic do_rm;
  logic [PW-1:0] rm_pos;
  logic [GW-1:0] fgrp;
  logic [CntW-1:0] fcnt, fdec, bcnt;
  always_comb begin
    do_rm = 1'b0; rm_pos = '0;
    if (mode_r == ModeFinish && any_b) begin
      do_rm = 1'b1; rm_pos = bpos;
    end else if (mode_r == ModeCheck && any_hit && !bnd_r[first_pos] && cmp_r[first_pos]) begin
      do_rm = 1'b1; rm_pos = first_pos;
    end
    fgrp = egrp_r[bpos];
    fcnt = cnt_r[fgrp];
    fdec = (fcnt != '0) ? fcnt - 1'b1 : fcnt;
    bcnt = cnt_r[grp_r];
  end

  // Apply operation to entries, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      for (int g = 0; g < GROUP_COUNT; g++) cnt_r[g] <= '0;
    end else if (cmd.execute) begin
      st_r <= StNotFound; rsp_r <= 1'b0; rtag_r <= '0; rkind_r <= 1'b0;
      case (mode_r)
        ModeCommit: begin
          if (full) st_r <= StFull;
          else begin
            vld_r[free_pos] <= 1'b1; eid_r[free_pos] <= id_r;
            cmp_r[free_pos] <= 1'b0; bnd_r[free_pos] <= 1'b0;
            etag_r[free_pos] <= '0; knd_r[free_pos] <= 1'b0;
            egrp_r[free_pos] <= '0;
            st_r <= StPending;
          end
        end
        ModeBind: begin
          if (any_hit) begin
            bnd_r[first_pos] <= 1'b1; etag_r[first_pos] <= tag_r;
            knd_r[first_pos] <= kind_r; egrp_r[first_pos] <= grp_r;
            if (bcnt < CntMax) cnt_r[grp_r] <= bcnt + 1'b1;
            st_r <= cmp_r[first_pos] ? StComplete : StPending;
          end
        end
        ModeFinish: begin
          if (any_hit) st_r <= StComplete;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (hit[i] && (!any_b || PW'(i) < bpos)) cmp_r[i] <= 1'b1;
          if (any_b) begin
            cnt_r[fgrp] <= fdec;
            if (fdec == '0) begin
              rsp_r <= 1'b1; rtag_r <= TagW'(etag_r[bpos]); rkind_r <= knd_r[bpos];
            end
          end
        end
        default: begin
          if (any_hit) st_r <= (bnd_r[first_pos] || cmp_r[first_pos]) ? StComplete : StPending;
        end
      endcase
      // Compact: shift entries above the removed one down by one
      if (do_rm) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (PW'(i) >= rm_pos) begin
            if (i + 1 < TABLE_DEPTH) begin
              vld_r[i] <= vld_r[i+1]; eid_r[i] <= eid_r[i+1];
              cmp_r[i] <= cmp_r[i+1] | (hit[i+1] && mode_r == ModeFinish && PW'(i+1) < bpos);
              bnd_r[i] <= bnd_r[i+1]; etag_r[i] <= etag_r[i+1];
              knd_r[i] <= knd_r[i+1]; egrp_r[i] <= egrp_r[i+1];
            end else vld_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  assign out_status = st_r;
  assign out_respond = rsp_r;
  assign out_respond_tag = rtag_r;
  assign out_respond_kind = rkind_r;
endmodule

// ===== design/transfer_completion_tracking_table_core.sv =====
// Top level of the transfer completion tracking table.
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | in_mode, in_request_id, in_waiter_tag, in_wait_kind,
//         |           |           | in_waiter_group
// out     | out_valid | out_stall | out_status, out_respond, out_respond_tag, out_respond_kind
// Each request passes through capture, one table update (parallel id compare,
// priority select and single-step compaction), then result hand-off; the next request
// is taken once the result leaves. Reset clears entry valid bits and group counters.
// A stalled result holds in its output register.
module transfer_completion_tracking_table_core #(
  parameter int TABLE_DEPTH = tctt_pkg::TableDepthDef,
  parameter int GROUP_COUNT = tctt_pkg::GroupCountDef,
  parameter int TAG_BITS = tctt_pkg::TagBitsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_mode,
  input  logic [tctt_pkg::IdW-1:0] in_request_id,
  input  logic [tctt_pkg::TagW-1:0] in_waiter_tag,
  input  logic in_wait_kind,
  input  logic [tctt_pkg::GrpW-1:0] in_waiter_group,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] out_status,
  output logic out_respond,
  output logic [tctt_pkg::TagW-1:0] out_respond_tag,
  output logic out_respond_kind
);
  import tctt_pkg::*;

  tctt_cmd_t cmd;

  tctt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  tctt_dp #(.TABLE_DEPTH(TABLE_DEPTH), .GROUP_COUNT(GROUP_COUNT), .TAG_BITS(TAG_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_mode(in_mode),
    .in_request_id(in_request_id), .in_waiter_tag(in_waiter_tag),
    .in_wait_kind(in_wait_kind), .in_waiter_group(in_waiter_group),
    .out_status(out_status), .out_respond(out_respond),
    .out_respond_tag(out_respond_tag), .out_respond_kind(out_respond_kind)
  );
endmodule

// ===== tb/tb_transfer_completion_tracking_table_core.sv =====
// Testbench for the transfer completion tracking table: random and directed requests vs. a predictor.
`timescale 1ns / 100ps

module tb_transfer_completion_tracking_table_core;
  import tctt_pkg::*;

  localparam int Depth = TableDepthDef;
  localparam int Groups = GroupCountDef;
  localparam int CycleLimit = 200000;
  localparam int RandomItems = 600;

  typedef struct packed {
    logic [1:0] status;
    logic respond;
    logic [TagW-1:0] tag;
    logic kind;
  } reply_t;

  // Tracks table contents and the queue of replies still owed by the block
  class tracking_scoreboard;
    bit valid [Depth];
    logic [IdW-1:0] ids [Depth];
    bit complete [Depth];
    bit bound [Depth];
    logic [TagW-1:0] tags [Depth];
    bit kinds [Depth];
    logic [GrpW-1:0] groups [Depth];
    logic [CntW-1:0] counts [Groups];
    reply_t owed [$];
    int errors;

    function new();
      errors = 0;
      foreach (valid[i]) valid[i] = 0;
      foreach (counts[g]) counts[g] = '0;
    endfunction

    // Close the gap left by a removed entry
    function void drop_entry(int pos);
      for (int i = pos; i + 1 < Depth; i++) begin
        valid[i] = valid[i+1];
        ids[i] = ids[i+1];
        complete[i] = complete[i+1];
        bound[i] = bound[i+1];
        tags[i] = tags[i+1];
        kinds[i] = kinds[i+1];
        groups[i] = groups[i+1];
      end
      valid[Depth-1] = 0;
    endfunction

    function int oldest_match(logic [IdW-1:0] id);
      for (int i = 0; i < Depth; i++)
        if (valid[i] && ids[i] == id) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (valid[i]) n += valid[i];
      return n;
    endfunction

    // Apply an accepted request and queue the reply it owes
    function void note_request(logic [1:0] mode, logic [IdW-1:0] id, logic [TagW-1:0] tag,
                               logic kind, logic [GrpW-1:0] grp);
      reply_t r;
      int pos;
      int g;
      r = '0;
      r.status = StNotFound;
      g = int'(grp) % Groups;
      case (mode)
        ModeCommit: begin
          pos = -1;
          for (int i = 0; i < Depth; i++)
            if (!valid[i] && pos < 0) pos = i;
          if (pos < 0) begin
            r.status = StFull;
          end else begin
            valid[pos] = 1;
            ids[pos] = id;
            complete[pos] = 0;
            bound[pos] = 0;
            tags[pos] = '0;
            kinds[pos] = 0;
            groups[pos] = '0;
            r.status = StPending;
          end
        end
        ModeBind: begin
          pos = oldest_match(id);
          if (pos >= 0) begin
            bound[pos] = 1;
            tags[pos] = tag;
            kinds[pos] = kind;
            groups[pos] = GrpW'(g);
            if (counts[g] < CntMax) counts[g]++;
            r.status = complete[pos] ? StComplete : StPending;
          end
        end
        ModeFinish: begin
          for (int i = 0; i < Depth; i++) begin
            if (valid[i] && ids[i] == id) begin
              r.status = StComplete;
              complete[i] = 1;
              if (bound[i]) begin
                g = int'(groups[i]) % Groups;
                if (counts[g] > 0) counts[g]--;
                if (counts[g] == 0) begin
                  r.respond = 1;
                  r.tag = tags[i];
                  r.kind = kinds[i];
                end
                drop_entry(i);
                break;
              end
            end
          end
        end
        default: begin
          pos = oldest_match(id);
          if (pos >= 0) begin
            if (bound[pos]) begin
              r.status = StComplete;
            end else if (complete[pos]) begin
              r.status = StComplete;
              drop_entry(pos);
            end else begin
              r.status = StPending;
            end
          end
        end
      endcase
      owed.push_back(r);
    endfunction

    // Compare one reply against the oldest owed one
    function void check_result(reply_t got);
      reply_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected reply %p", got);
        return;
      end
      want = owed.pop_front();
      if (got.status !== want.status || got.respond !== want.respond ||
          got.tag !== want.tag || got.kind !== want.kind) begin
        errors++;
        if (errors <= 10) $display("reply mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_mode;
  logic [IdW-1:0] in_request_id;
  logic [TagW-1:0] in_waiter_tag;
  logic in_wait_kind;
  logic [GrpW-1:0] in_waiter_group;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic out_respond;
  logic [TagW-1:0] out_respond_tag;
  logic out_respond_kind;

  tracking_scoreboard board;
  int accepted;
  int cycles;
  logic [IdW-1:0] id_pool [8];

  transfer_completion_tracking_table_core DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_request_id(in_request_id),
    .in_waiter_tag(in_waiter_tag),
    .in_wait_kind(in_wait_kind),
    .in_waiter_group(in_waiter_group),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_respond(out_respond),
    .out_respond_tag(out_respond_tag),
    .out_respond_kind(out_respond_kind)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Hold the request until accepted; call right after a rising edge
  task automatic send_request(logic [1:0] mode, logic [IdW-1:0] id, logic [TagW-1:0] tag,
                              logic kind, logic [GrpW-1:0] grp);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_request_id <= id;
    in_waiter_tag <= tag;
    in_wait_kind <= kind;
    in_waiter_group <= grp;
    do @(posedge clk); while (in_stall);
    board.note_request(mode, id, tag, kind, grp);
    accepted++;
  endtask

  function automatic logic [IdW-1:0] pick_id();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return id_pool[$urandom_range(0, 7)];
  endfunction

  // Receiver: rotating stall patterns, with one long hold-off once 150 requests are accepted
  initial begin
    int hold_left;
    bit held;
    int phase;
    hold_left = 0;
    held = 0;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      phase = (cycles / 400) % 3;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!held && accepted >= 150) begin
        held = 1;
        hold_left = 300;
        out_stall <= 1'b1;
      end else if (phase == 0) begin
        out_stall <= 1'b0;
      end else if (phase == 1) begin
        out_stall <= ($urandom_range(0, 9) < 3);
      end else begin
        out_stall <= ((cycles % 7) < 3);
      end
    end
  end

  // Check every reply taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_status, out_respond, out_respond_tag, out_respond_kind});
  end

  // Cycle watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    int pick;
    int commit_share;
    logic [1:0] mode;
    board = new();
    accepted = 0;
    id_pool = '{64'd0, {IdW{1'b1}}, 64'd1, 64'h8000_0000_0000_0000,
                64'h5555_aaaa_0f0f_f0f0, 64'd7, 64'd9, 64'hdead_0000_0000_beef};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = ModeCommit;
    in_request_id = '0;
    in_waiter_tag = '0;
    in_wait_kind = 1'b0;
    in_waiter_group = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extremes, every operation and the listed corner cases
    send_request(ModeCommit, '0, '0, 0, '0);
    send_request(ModeCommit, '1, '0, 0, '0);
    send_request(ModeBind, '1, '1, 1, 4'd15);
    send_request(ModeBind, 64'd5, 16'h1234, 0, 4'd3);
    send_request(ModeCheck, '0, '0, 0, '0);
    send_request(ModeFinish, '0, '0, 0, '0);
    send_request(ModeCheck, '0, '0, 0, '0);
    send_request(ModeCheck, '0, '0, 0, '0);
    send_request(ModeFinish, '1, '0, 0, '0);
    send_request(ModeFinish, '1, '0, 0, '0);
    // Bind after completion, then check a bound entry
    send_request(ModeCommit, 64'd7, '0, 0, '0);
    send_request(ModeFinish, 64'd7, '0, 0, '0);
    send_request(ModeBind, 64'd7, 16'h00ff, 0, 4'd0);
    send_request(ModeCheck, 64'd7, '0, 0, '0);
    send_request(ModeFinish, 64'd7, '0, 0, '0);
    // Rebind moves the waiter to a new group
    send_request(ModeCommit, 64'd9, '0, 0, '0);
    send_request(ModeBind, 64'd9, 16'haaaa, 1, 4'd1);
    send_request(ModeBind, 64'd9, 16'h5555, 0, 4'd2);
    send_request(ModeFinish, 64'd9, '0, 0, '0);
    // Duplicate ids: bind hits the oldest
    send_request(ModeCommit, 64'd11, '0, 0, '0);
    send_request(ModeCommit, 64'd11, '0, 0, '0);
    send_request(ModeBind, 64'd11, 16'h0001, 1, 4'd6);
    send_request(ModeFinish, 64'd11, '0, 0, '0);
    send_request(ModeCheck, 64'd11, '0, 0, '0);
    // Saturate one group counter
    send_request(ModeCommit, 64'd13, '0, 0, '0);
    for (int i = 0; i < 64; i++) send_request(ModeBind, 64'd13, 16'(i), 0, 4'd4);
    send_request(ModeFinish, 64'd13, '0, 0, '0);

    // Random bursts; the early part and a later stretch lean on commits to fill the table
    for (int n = 0; n < RandomItems; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < RandomItems; b++, n++) begin
        commit_share = (n < 150 || (n >= 350 && n < 420)) ? 65 : 30;
        pick = $urandom_range(0, 99);
        if (pick < commit_share) mode = ModeCommit;
        else if (pick < commit_share + (100 - commit_share) / 3) mode = ModeBind;
        else if (pick < commit_share + 2 * (100 - commit_share) / 3) mode = ModeFinish;
        else mode = ModeCheck;
        send_request(mode, pick_id(), 16'($urandom), 1'($urandom), 4'($urandom));
      end
      // Idle gap between bursts, sometimes none
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // Drain the owed replies, then let the block settle
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== transfer_completion_tracking_table_core.f =====
design/tctt_pkg.sv
design/tctt_ctrl.sv
design/tctt_dp.sv
design/transfer_completion_tracking_table_core.sv
tb/tb_transfer_completion_tracking_table_core.sv
